>>> design/dst_pkg.sv
// Package for the segment traceback block: sizes, memory entry types,
// status codes and the class remapping table. No dependencies.
`timescale 1ns / 1ps

package dst_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int NUM_CLASSES = 16;

  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int START_W    = 6;
  localparam int CLASS_W    = $clog2(NUM_CLASSES);
  localparam int IN_START_W = 7;
  localparam int IN_CLASS_W = 5;
  localparam int IDX_W      = 6;
  localparam int FRAME_W    = 7;
  localparam int LABEL_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int CLASS_IN_N = 2 ** IN_CLASS_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TRACE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_BAD   = 2'd2
  } status_e;

  typedef logic [CLASS_W-1:0] cls_t;
  typedef cls_t [CLASS_IN_N-1:0] class_lut_t;

  // One frame's backpointer: 0-based start and 0-based class.
  typedef struct packed {
    logic [START_W-1:0] start;
    cls_t               cls;
  } frame_ent_t;

  // One step of the backward walk, kept for forward-order emission.
  typedef struct packed {
    logic [ADDR_W-1:0]  frame;
    logic [START_W-1:0] start;
    cls_t               cls;
  } chain_ent_t;

  // 1-based input class to 0-based stored class, wrapped modulo NUM_CLASSES.
  function automatic class_lut_t build_class_lut();
    class_lut_t lut;
    for (int i = 0; i < CLASS_IN_N; i++) begin
      lut[i] = CLASS_W'((i + NUM_CLASSES - 1) % NUM_CLASSES);
    end
    return lut;
  endfunction

  localparam class_lut_t CLASS_LUT = build_class_lut();

endpackage

>>> design/dst_frame_mem.sv
// Frame store: one backpointer entry per loaded frame, 1W1R, registered read.
// Maps the raw 1-based load fields to stored form. Depends on dst_pkg.
`timescale 1ns / 1ps

module dst_frame_mem import dst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [IN_START_W-1:0] seg_start_i,
  input  logic [IN_CLASS_W-1:0] seg_class_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output frame_ent_t            rdata_o
);

  frame_ent_t mem_q [MAX_FRAMES];
  frame_ent_t rdata_q;
  frame_ent_t wdata;

  // start - 1 wraps modulo 64, so a start of 0 stores as 63
  assign wdata.start = START_W'(seg_start_i - IN_START_W'(1));
  assign wdata.cls   = CLASS_LUT[seg_class_i];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dst_chain_mem.sv
// Chain buffer: records each step of the backward walk so the segments can
// be replayed earliest first. 1W1R, registered read. Depends on dst_pkg.
`timescale 1ns / 1ps

module dst_chain_mem import dst_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  chain_ent_t        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output chain_ent_t        rdata_o
);

  chain_ent_t mem_q [MAX_FRAMES];
  chain_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dp_segment_traceback.sv
// Channel   | Ports                                          | Handshake
// request   | kind_i, seg_start_i, seg_class_i              | start && !busy
// result    | seg_index_o, seg_first_o, seg_boundary_o,     | valid_o, one cycle
//           | label_o, last_o, status_o                      |
//
// Load: busy stays low; loads past MAX_FRAMES are dropped. Trace of S
// segments: S walk steps over the frame store (one read per step, next
// address taken straight from the read data), then a replay of the chain
// buffer; results come out one per cycle through the chain read and output
// registers. busy is high while a trace walks or replays. Empty store:
// status result the cycle after accept. Bad backpointer: status result the
// cycle after the walk step that reads it. Receiver never stalls.
// Reset clears the entry count and control; memories are not cleared.
// Top level: FSM plus frame store and chain buffer. Depends on dst_pkg.
`timescale 1ns / 1ps

module dp_segment_traceback import dst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [IN_START_W-1:0] seg_start_i,
  input  logic [IN_CLASS_W-1:0] seg_class_i,
  output logic                  valid_o,
  output logic [IDX_W-1:0]      seg_index_o,
  output logic [FRAME_W-1:0]    seg_first_o,
  output logic [FRAME_W-1:0]    seg_boundary_o,
  output logic [LABEL_W-1:0]    label_o,
  output logic                  last_o,
  output logic [STATUS_W-1:0]   status_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  v_q, v_d;      // frame whose entry is on the read port
  logic [ADDR_W-1:0]  k_q, k_d;      // walk step
  logic [ADDR_W-1:0]  e_q, e_d;      // replay read index, counts down
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic               p_valid_q, p_valid_d;
  logic [ADDR_W-1:0]  p_pos_q, p_pos_d;
  logic               p_last_q, p_last_d;

  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [FRAME_W-1:0] out_first_q, out_first_d;
  logic [FRAME_W-1:0] out_bnd_q, out_bnd_d;
  logic [LABEL_W-1:0] out_label_q, out_label_d;
  logic               out_last_q, out_last_d;
  status_e            out_status_q, out_status_d;

  logic               accept;
  logic               load_we;
  logic [ADDR_W-1:0]  fr_raddr;
  frame_ent_t         fr_rd;
  logic [ADDR_W-1:0]  nxt_v;
  logic               ch_we;
  chain_ent_t         ch_wdata;
  logic [ADDR_W-1:0]  ch_raddr;
  chain_ent_t         ch_rd;
  logic [CLASS_W:0]   label_full;

  assign busy    = (state_q != S_IDLE) || p_valid_q;
  assign accept  = start && !busy;
  // trace cannot start in the same cycle as a load, so no forwarding
  assign load_we = accept && (kind_i == KIND_LOAD) && (cnt_q < CNT_W'(MAX_FRAMES));
  assign nxt_v   = ADDR_W'(fr_rd.start - START_W'(1));

  assign ch_wdata.frame = v_q;
  assign ch_wdata.start = fr_rd.start;
  assign ch_wdata.cls   = fr_rd.cls;
  assign label_full     = {1'b0, ch_rd.cls} + (CLASS_W + 1)'(1);

  dst_frame_mem u_frame_mem (
    .clk_i       (clk_i),
    .we_i        (load_we),
    .waddr_i     (ADDR_W'(cnt_q)),
    .seg_start_i (seg_start_i),
    .seg_class_i (seg_class_i),
    .raddr_i     (fr_raddr),
    .rdata_o     (fr_rd)
  );

  dst_chain_mem u_chain_mem (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (k_q),
    .wdata_i (ch_wdata),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rd)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    v_d          = v_q;
    k_d          = k_q;
    e_d          = e_q;
    pos_d        = pos_q;
    p_valid_d    = 1'b0;
    p_pos_d      = pos_q;
    p_last_d     = 1'b0;
    ch_we        = 1'b0;
    ch_raddr     = e_q;
    fr_raddr     = v_q;
    out_valid_d  = 1'b0;
    out_idx_d    = out_idx_q;
    out_first_d  = out_first_q;
    out_bnd_d    = out_bnd_q;
    out_label_d  = out_label_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_LOAD) begin
            if (load_we) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end else if (cnt_q == '0) begin
            out_valid_d  = 1'b1;
            out_idx_d    = '0;
            out_first_d  = '0;
            out_bnd_d    = '0;
            out_label_d  = '0;
            out_last_d   = 1'b1;
            out_status_d = STATUS_EMPTY;
          end else begin
            v_d      = ADDR_W'(cnt_q - CNT_W'(1));
            fr_raddr = ADDR_W'(cnt_q - CNT_W'(1));
            k_d      = '0;
            state_d  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (fr_rd.start > START_W'(v_q)) begin
          out_valid_d  = 1'b1;
          out_idx_d    = '0;
          out_first_d  = '0;
          out_bnd_d    = '0;
          out_label_d  = '0;
          out_last_d   = 1'b1;
          out_status_d = STATUS_BAD;
          state_d      = S_IDLE;
        end else begin
          ch_we = 1'b1;
          if (fr_rd.start == '0) begin
            e_d     = k_q;
            pos_d   = '0;
            state_d = S_EMIT;
          end else begin
            v_d      = nxt_v;
            fr_raddr = nxt_v;
            k_d      = k_q + ADDR_W'(1);
          end
        end
      end
      S_EMIT: begin
        // replay newest step first: it holds the earliest segment
        p_valid_d = 1'b1;
        p_pos_d   = pos_q;
        p_last_d  = (e_q == '0);
        e_d       = e_q - ADDR_W'(1);
        pos_d     = pos_q + ADDR_W'(1);
        if (e_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (p_valid_q) begin
      out_valid_d  = 1'b1;
      out_idx_d    = IDX_W'(p_pos_q);
      out_first_d  = FRAME_W'(ch_rd.start) + FRAME_W'(1);
      out_bnd_d    = FRAME_W'(ch_rd.frame) + FRAME_W'(2);
      out_label_d  = LABEL_W'(label_full);
      out_last_d   = p_last_q;
      out_status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q          <= v_d;
    k_q          <= k_d;
    e_q          <= e_d;
    pos_q        <= pos_d;
    p_pos_q      <= p_pos_d;
    p_last_q     <= p_last_d;
    out_idx_q    <= out_idx_d;
    out_first_q  <= out_first_d;
    out_bnd_q    <= out_bnd_d;
    out_label_q  <= out_label_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign valid_o        = out_valid_q;
  assign seg_index_o    = out_idx_q;
  assign seg_first_o    = out_first_q;
  assign seg_boundary_o = out_bnd_q;
  assign label_o        = out_label_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAMES))
    else $error("entry count beyond capacity");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (CNT_W'(k_q) < cnt_q) && (CNT_W'(v_q) < cnt_q))
    else $error("walk step or frame outside loaded entries");

  a_bad_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_BAD) |-> $past(state_q == S_WALK))
    else $error("bad backpointer result not produced by the walk");

  a_burst_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap inside a segment burst");
`endif

endmodule
